/* src/gas_alarm_hold_hysteresis_macros.svh */
// Assertion macros used by the gas alarm core.
`ifndef GAS_ALARM_HOLD_HYSTERESIS_MACROS_SVH
`define GAS_ALARM_HOLD_HYSTERESIS_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define GAM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/gam_pkg.sv */
// Package with the types, register indexes and reset values of the gas alarm.
`timescale 1ns / 1ps

package gam_pkg;

    localparam int unsigned PPM_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [1:0] {
        LVL_NONE  = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ALARM = 2'd2
    } t_level;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_ALARM_PPM     = 3'd0;
    localparam logic [IDX_W-1:0] REG_WARN_PPM      = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLEAR_PPM     = 3'd2;
    localparam logic [IDX_W-1:0] REG_WARN_HOLD_MS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLEAR_HOLD_MS = 3'd4;
    localparam logic [IDX_W-1:0] REG_WARMUP_MS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_FRESH_MS      = 3'd6;
    localparam logic [IDX_W-1:0] REG_BOOT_TIME_MS  = 3'd7;

    // Reset values
    localparam logic [PPM_W-1:0]  RST_ALARM_PPM     = 16'd100;
    localparam logic [PPM_W-1:0]  RST_WARN_PPM      = 16'd35;
    localparam logic [PPM_W-1:0]  RST_CLEAR_PPM     = 16'd30;
    localparam logic [TIME_W-1:0] RST_WARN_HOLD_MS  = 32'd180000;
    localparam logic [TIME_W-1:0] RST_CLEAR_HOLD_MS = 32'd30000;
    localparam logic [TIME_W-1:0] RST_WARMUP_MS     = 32'd300000;
    localparam logic [TIME_W-1:0] RST_FRESH_MS      = 32'd5000;
    localparam logic [TIME_W-1:0] RST_BOOT_TIME_MS  = 32'd0;

    typedef struct packed {
        logic [PPM_W-1:0]  alarm_ppm;
        logic [PPM_W-1:0]  warn_ppm;
        logic [PPM_W-1:0]  clear_ppm;
        logic [TIME_W-1:0] warn_hold_ms;
        logic [TIME_W-1:0] clear_hold_ms;
        logic [TIME_W-1:0] warmup_ms;
        logic [TIME_W-1:0] fresh_ms;
        logic [TIME_W-1:0] boot_time_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              sample_valid;
        logic [TIME_W-1:0] sample_time_ms;
        logic [PPM_W-1:0]  gas_ppm;
    } t_sample;

    typedef struct packed {
        t_level level;
        logic   warming_up;
        logic   sample_fresh;
    } t_result;

endpackage

/* src/gas_alarm_hold_hysteresis.sv */
// Top level of the gas alarm with hold timers and hysteresis.
`timescale 1ns / 1ps

// Gas alarm: each accepted item is one gas sample (current time, valid flag,
// capture time, ppm). The block keeps an alarm level (0 none, 1 warn,
// 2 alarm) and returns one result item per sample with the level after that
// sample, the warm-up flag and the freshness flag. A fresh reading at or
// above alarm_ppm raises alarm at once, even in warm-up; outside warm-up a
// reading at or above warn_ppm held for warn_hold_ms raises warn from none,
// and while a level is set a reading below clear_ppm held for clear_hold_ms
// returns it to none. Stale or invalid samples stop both hold timers. All
// time differences wrap modulo 2^32. Throughput is one item per clock while
// i_ready is high: the sample is registered, then the combinational
// level/timer update writes the state and the result register together, so
// the next sample sees the updated state right away. The accepted item
// passes the input register and then the result register before o_valid
// rises. The result register lets a new item enter while an earlier result
// still waits; o_ready drops only when both the input register and the
// result register are full and i_ready is low.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the
// next clock edge and must only be issued while no item is in flight.
module gas_alarm_hold_hysteresis
    import gam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // sample items
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_sample_valid,
    input  logic [TIME_W-1:0] i_sample_time_ms,
    input  logic [PPM_W-1:0]  i_gas_ppm,
    // result items
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_alarm_level,
    output logic              o_warming_up,
    output logic              o_sample_fresh
);

    t_cfg    cfg;
    t_sample r_sample;
    logic    r_in_vld;
    t_result core_result;
    t_result r_result;
    logic    r_out_vld;
    logic    advance;
    logic    in_take;

    gam_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move the registered sample into the result stage whenever the result
    // register is empty or is being drained this cycle.
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;
    assign in_take = i_valid && o_ready;

    // Input register: hold the sample until the result stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample.now_ms         <= i_now_ms;
            r_sample.sample_valid   <= i_sample_valid;
            r_sample.sample_time_ms <= i_sample_time_ms;
            r_sample.gas_ppm        <= i_gas_ppm;
        end
    end

    // Update the level and timers; state is committed only on advance.
    gam_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_sample (r_sample),
        .o_result (core_result)
    );

    // Result register: hold the item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_alarm_level  = r_result.level;
    assign o_warming_up   = r_result.warming_up;
    assign o_sample_fresh = r_result.sample_fresh;

endmodule

/* src/gam_cfg.sv */
// Configuration register file of the gas alarm.
`timescale 1ns / 1ps

module gam_cfg
    import gam_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_ppm     <= RST_ALARM_PPM;
            r_cfg.warn_ppm      <= RST_WARN_PPM;
            r_cfg.clear_ppm     <= RST_CLEAR_PPM;
            r_cfg.warn_hold_ms  <= RST_WARN_HOLD_MS;
            r_cfg.clear_hold_ms <= RST_CLEAR_HOLD_MS;
            r_cfg.warmup_ms     <= RST_WARMUP_MS;
            r_cfg.fresh_ms      <= RST_FRESH_MS;
            r_cfg.boot_time_ms  <= RST_BOOT_TIME_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ALARM_PPM:     r_cfg.alarm_ppm     <= i_cfg_data[PPM_W-1:0];
                REG_WARN_PPM:      r_cfg.warn_ppm      <= i_cfg_data[PPM_W-1:0];
                REG_CLEAR_PPM:     r_cfg.clear_ppm     <= i_cfg_data[PPM_W-1:0];
                REG_WARN_HOLD_MS:  r_cfg.warn_hold_ms  <= i_cfg_data[TIME_W-1:0];
                REG_CLEAR_HOLD_MS: r_cfg.clear_hold_ms <= i_cfg_data[TIME_W-1:0];
                REG_WARMUP_MS:     r_cfg.warmup_ms     <= i_cfg_data[TIME_W-1:0];
                REG_FRESH_MS:      r_cfg.fresh_ms      <= i_cfg_data[TIME_W-1:0];
                REG_BOOT_TIME_MS:  r_cfg.boot_time_ms  <= i_cfg_data[TIME_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/gam_core.sv */
// Alarm level and hold timer state with its per-sample update logic.
`timescale 1ns / 1ps

module gam_core
    import gam_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cfg    i_cfg,
    input  t_sample i_sample,
    output t_result o_result
);

    `include "gas_alarm_hold_hysteresis_macros.svh"

    t_level            r_level,       n_level;
    logic              r_warn_run,    n_warn_run;
    logic [TIME_W-1:0] r_warn_start,  n_warn_start;
    logic              r_clear_run,   n_clear_run;
    logic [TIME_W-1:0] r_clear_start, n_clear_start;

    logic [TIME_W-1:0] boot_age;
    logic [TIME_W-1:0] sample_age;
    logic [TIME_W-1:0] warn_elapsed;
    logic [TIME_W-1:0] clear_elapsed;
    logic              warming;
    logic              fresh;
    logic              hit_alarm;

    // All differences wrap modulo 2^32. A timer that is not running starts
    // now, so its elapsed time is zero.
    assign boot_age      = i_sample.now_ms - i_cfg.boot_time_ms;
    assign sample_age    = i_sample.now_ms - i_sample.sample_time_ms;
    assign warn_elapsed  = r_warn_run  ? (i_sample.now_ms - r_warn_start)  : '0;
    assign clear_elapsed = r_clear_run ? (i_sample.now_ms - r_clear_start) : '0;
    assign warming       = (boot_age <= i_cfg.warmup_ms);
    assign fresh         = i_sample.sample_valid && (sample_age <= i_cfg.fresh_ms);
    assign hit_alarm     = (i_sample.gas_ppm >= i_cfg.alarm_ppm);

    always_comb begin
        n_level       = r_level;
        n_warn_run    = r_warn_run;
        n_warn_start  = r_warn_start;
        n_clear_run   = r_clear_run;
        n_clear_start = r_clear_start;
        priority if (!fresh) begin
            n_warn_run  = 1'b0;
            n_clear_run = 1'b0;
        end else if (hit_alarm) begin
            n_level     = LVL_ALARM;
            n_warn_run  = 1'b0;
            n_clear_run = 1'b0;
        end else if (warming) begin
            // hold everything during warm-up
        end else if (i_sample.gas_ppm >= i_cfg.warn_ppm) begin
            n_clear_run = 1'b0;
            n_warn_run  = 1'b1;
            if (!r_warn_run) begin
                n_warn_start = i_sample.now_ms;
            end
            if (r_level == LVL_NONE && warn_elapsed >= i_cfg.warn_hold_ms) begin
                n_level = LVL_WARN;
            end
        end else begin
            n_warn_run = 1'b0;
            if (r_level != LVL_NONE && i_sample.gas_ppm < i_cfg.clear_ppm) begin
                n_clear_run = 1'b1;
                if (!r_clear_run) begin
                    n_clear_start = i_sample.now_ms;
                end
                if (clear_elapsed >= i_cfg.clear_hold_ms) begin
                    n_level     = LVL_NONE;
                    n_clear_run = 1'b0;
                end
            end else begin
                n_clear_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_NONE;
            r_warn_run  <= 1'b0;
            r_clear_run <= 1'b0;
        end else if (i_en) begin
            r_level     <= n_level;
            r_warn_run  <= n_warn_run;
            r_clear_run <= n_clear_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_warn_start  <= n_warn_start;
            r_clear_start <= n_clear_start;
        end
    end

    assign o_result.level        = n_level;
    assign o_result.warming_up   = warming;
    assign o_result.sample_fresh = fresh;

    `GAM_ASSERT_ALWAYS(a_timers_exclusive, i_clk, i_rst_n, !(r_warn_run && r_clear_run), "warn and clear timers both running")
    `GAM_ASSERT_ALWAYS(a_clear_needs_level, i_clk, i_rst_n, !r_clear_run || (r_level != LVL_NONE), "clear timer running at level none")
    `GAM_ASSERT_NEXT(a_stale_keeps_level, i_clk, i_rst_n, i_en && !fresh, r_level == $past(r_level), "stale sample changed the level")
    `GAM_ASSERT_NEXT(a_alarm_immediate, i_clk, i_rst_n, i_en && fresh && hit_alarm, r_level == LVL_ALARM, "alarm reading did not raise alarm")

endmodule
